FILE: rtl/mavp_pkg.sv
// shared constants, status codes, extra-byte rom and crc step for the mavlink v1 parser
// no dependencies
package mavp_pkg;

  localparam int unsigned ROM_SIZE       = 100;
  localparam int unsigned KNOWN_ID_COUNT = 100;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  START_INIT = 8'hFE;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [7:0] EXTRA_ROM [ROM_SIZE] = '{
    8'd50,  8'd124, 8'd137, 8'd0,   8'd237, 8'd217, 8'd104, 8'd119, 8'd0,   8'd0,
    8'd0,   8'd89,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd214, 8'd159, 8'd220, 8'd168, 8'd24,  8'd23,  8'd170, 8'd144, 8'd67,  8'd115,
    8'd39,  8'd246, 8'd185, 8'd104, 8'd237, 8'd244, 8'd222, 8'd212, 8'd9,   8'd254,
    8'd230, 8'd28,  8'd28,  8'd132, 8'd221, 8'd232, 8'd11,  8'd153, 8'd41,  8'd39,
    8'd78,  8'd196, 8'd0,   8'd0,   8'd15,  8'd3,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd167, 8'd183, 8'd119, 8'd191, 8'd118, 8'd148, 8'd21,  8'd0,   8'd243, 8'd124,
    8'd0,   8'd0,   8'd38,  8'd20,  8'd158, 8'd152, 8'd143, 8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  function automatic logic [7:0] extra_byte(input logic [7:0] msgid);
    logic [7:0] r;
    r = 8'd0;
    if ({1'b0, msgid} < 9'(ROM_SIZE)) begin
      r = EXTRA_ROM[msgid[6:0]];
    end
    return r;
  endfunction

  // mcrf4xx byte update
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [7:0] t;
    t = d ^ c[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, c[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

FILE: rtl/mavlink_v1_frame_parser.sv
// mavlink v1 frame parser: start hunt, header capture, payload streaming, crc and message id check
// depends on mavp_pkg
//
// channel  dir  beat contents
// s_*      in   tdata[7:0] rx_byte
// m_*      out  tuser payload_strobe, tlast frame_done, tdata header/payload fields
// cfg      in   start_byte_we / start_byte_wdata, written at once
//
// one beat per cycle while the output is not stalled; each input beat yields one output beat in the next cycle
// the crc byte update and position compare are combinational, in front of the output register
// a stalled output register holds the input back until the beat is taken
// rst is synchronous: hunting for start, crc at ffff, start byte fe
module mavlink_v1_frame_parser
  import mavp_pkg::*;
#(
  parameter int unsigned KNOWN_IDS = KNOWN_ID_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_byte_we,
  input  logic [7:0]  start_byte_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // payload_byte, payload_index, frame_ok, frame_status,
                                 // frame_length, frame_seq, frame_sysid, frame_compid,
                                 // frame_msgid, zero fill
  output logic        m_tuser,   // payload_strobe
  output logic        m_tlast    // frame_done
);

  localparam logic [8:0] ID_LIMIT = 9'(KNOWN_IDS);

  logic [7:0]  start_byte;
  logic [8:0]  byte_position, byte_position_next;
  logic [7:0]  hdr_length, hdr_length_next;
  logic [7:0]  hdr_seq, hdr_seq_next;
  logic [7:0]  hdr_sysid, hdr_sysid_next;
  logic [7:0]  hdr_compid, hdr_compid_next;
  logic [7:0]  hdr_msgid, hdr_msgid_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  checksum_low, checksum_low_next;

  logic        o_strobe, o_done, o_ok;
  logic [7:0]  o_byte, o_index, o_len, o_seq, o_sys, o_comp, o_msg;
  logic [1:0]  o_status;

  logic        out_valid;
  logic [63:0] out_data;
  logic        out_user, out_last;

  logic        in_take;
  logic [8:0]  pay_end;
  logic [15:0] crc_fin;

  assign s_tready = !out_valid || m_tready;
  assign in_take  = s_tvalid && s_tready;
  assign pay_end  = 9'd6 + {1'b0, hdr_length};
  assign crc_fin  = crc_step(running_crc, extra_byte(hdr_msgid));

  always_comb begin
    byte_position_next = byte_position;
    hdr_length_next    = hdr_length;
    hdr_seq_next       = hdr_seq;
    hdr_sysid_next     = hdr_sysid;
    hdr_compid_next    = hdr_compid;
    hdr_msgid_next     = hdr_msgid;
    running_crc_next   = running_crc;
    checksum_low_next  = checksum_low;
    o_strobe = 1'b0;
    o_byte   = 8'd0;
    o_index  = 8'd0;
    o_done   = 1'b0;
    o_ok     = 1'b0;
    o_status = STATUS_OK;
    o_len    = 8'd0;
    o_seq    = 8'd0;
    o_sys    = 8'd0;
    o_comp   = 8'd0;
    o_msg    = 8'd0;
    if (byte_position == 9'd0) begin
      if (s_tdata == start_byte) begin
        byte_position_next = 9'd1;
        running_crc_next   = CRC_INIT;
      end
    end else if (byte_position <= 9'd5) begin
      case (byte_position)
        9'd1:    hdr_length_next = s_tdata;
        9'd2:    hdr_seq_next    = s_tdata;
        9'd3:    hdr_sysid_next  = s_tdata;
        9'd4:    hdr_compid_next = s_tdata;
        default: hdr_msgid_next  = s_tdata;
      endcase
      running_crc_next   = crc_step(running_crc, s_tdata);
      byte_position_next = byte_position + 9'd1;
    end else if (byte_position < pay_end) begin
      running_crc_next   = crc_step(running_crc, s_tdata);
      o_strobe           = 1'b1;
      o_byte             = s_tdata;
      o_index            = 8'(byte_position - 9'd6);
      byte_position_next = byte_position + 9'd1;
    end else if (byte_position == pay_end) begin
      checksum_low_next  = s_tdata;
      byte_position_next = byte_position + 9'd1;
    end else begin
      if ({1'b0, hdr_msgid} >= ID_LIMIT) begin
        o_status = STATUS_UNKNOWN;
      end else if (crc_fin != {s_tdata, checksum_low}) begin
        o_status = STATUS_CRC_BAD;
      end
      o_done             = 1'b1;
      o_ok               = (o_status == STATUS_OK);
      o_len              = hdr_length;
      o_seq              = hdr_seq;
      o_sys              = hdr_sysid;
      o_comp             = hdr_compid;
      o_msg              = hdr_msgid;
      byte_position_next = 9'd0;
      running_crc_next   = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_INIT;
      byte_position <= 9'd0;
      hdr_length    <= 8'd0;
      hdr_seq       <= 8'd0;
      hdr_sysid     <= 8'd0;
      hdr_compid    <= 8'd0;
      hdr_msgid     <= 8'd0;
      running_crc   <= CRC_INIT;
      checksum_low  <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (start_byte_we) begin
        start_byte <= start_byte_wdata;
      end
      if (in_take) begin
        byte_position <= byte_position_next;
        hdr_length    <= hdr_length_next;
        hdr_seq       <= hdr_seq_next;
        hdr_sysid     <= hdr_sysid_next;
        hdr_compid    <= hdr_compid_next;
        hdr_msgid     <= hdr_msgid_next;
        running_crc   <= running_crc_next;
        checksum_low  <= checksum_low_next;
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data <= {5'd0, o_msg, o_comp, o_sys, o_seq, o_len, o_status, o_ok, o_index, o_byte};
      out_user <= o_strobe;
      out_last <= o_done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= 9'd262)
    else $error("byte position beyond longest frame");

  a_strobe_not_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser && m_tlast))
    else $error("payload beat marked as frame end");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[16]) |-> (m_tlast && m_tdata[18:17] == STATUS_OK))
    else $error("frame ok without clean frame end");

  a_hunt_stays: assert property (@(posedge clk) disable iff (rst)
    (in_take && byte_position == 9'd0 && s_tdata != start_byte) |=>
      (byte_position == 9'd0 && !m_tuser && !m_tlast))
    else $error("left start hunt on a non-start byte");
`endif

endmodule

FILE: tb/mavlink_v1_frame_parser_tb.sv
// testbench for mavlink_v1_frame_parser: random and hand-built frames, mostly under random idling,
// checked beat by beat against an in-bench parser model held in a small scoreboard class
// depends on mavp_pkg and rtl/mavlink_v1_frame_parser.sv
`timescale 1ns / 1ps

module mavlink_v1_frame_parser_tb;
  import mavp_pkg::*;

  typedef struct packed {
    logic       strobe;
    logic       done;
    logic [4:0] fill;
    logic [7:0] msgid;
    logic [7:0] compid;
    logic [7:0] sysid;
    logic [7:0] seq;
    logic [7:0] length;
    logic [1:0] status;
    logic       ok;
    logic [7:0] pindex;
    logic [7:0] pbyte;
  } parse_beat_t;

  class parser_scoreboard;
    logic [7:0]  start_byte;
    int unsigned pos;
    logic [7:0]  hdr_len, hdr_seq, hdr_sys, hdr_comp, hdr_msg;
    logic [15:0] crc;
    logic [7:0]  cks_low;
    parse_beat_t beats_due[$];
    int          errors;

    function void reset_state();
      start_byte = START_INIT;
      pos = 0;
      hdr_len = '0;
      hdr_seq = '0;
      hdr_sys = '0;
      hdr_comp = '0;
      hdr_msg = '0;
      crc = CRC_INIT;
      cks_low = '0;
      beats_due.delete();
      errors = 0;
    endfunction

    function void set_start(logic [7:0] v);
      start_byte = v;
    endfunction

    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
      logic [7:0]  t;
      logic [15:0] w;
      t = d ^ c[7:0];
      t = t ^ (t << 4);
      w = {8'h00, t};
      return (c >> 8) ^ (w << 8) ^ (w << 3) ^ (w >> 4);
    endfunction

    function logic [7:0] extra_for(logic [7:0] msgid);
      return (int'(msgid) < ROM_SIZE) ? EXTRA_ROM[int'(msgid)] : 8'd0;
    endfunction

    function void take_rx_byte(logic [7:0] b);
      parse_beat_t e;
      logic [15:0] fin;
      e = '0;
      if (pos == 0) begin
        if (b == start_byte) begin
          pos = 1;
          crc = CRC_INIT;
        end
      end else if (pos <= 5) begin
        case (pos)
          1: hdr_len = b;
          2: hdr_seq = b;
          3: hdr_sys = b;
          4: hdr_comp = b;
          default: hdr_msg = b;
        endcase
        crc = crc_next(crc, b);
        pos++;
      end else if (pos < 6 + int'(hdr_len)) begin
        crc = crc_next(crc, b);
        e.strobe = 1'b1;
        e.pbyte = b;
        e.pindex = 8'(pos - 6);
        pos++;
      end else if (pos == 6 + int'(hdr_len)) begin
        cks_low = b;
        pos++;
      end else begin
        // unknown id wins over a bad checksum
        if (int'(hdr_msg) >= KNOWN_ID_COUNT) begin
          e.status = STATUS_UNKNOWN;
        end else begin
          fin = crc_next(crc, extra_for(hdr_msg));
          e.status = (fin == {b, cks_low}) ? STATUS_OK : STATUS_CRC_BAD;
        end
        e.done = 1'b1;
        e.ok = (e.status == STATUS_OK);
        e.length = hdr_len;
        e.seq = hdr_seq;
        e.sysid = hdr_sys;
        e.compid = hdr_comp;
        e.msgid = hdr_msg;
        pos = 0;
        crc = CRC_INIT;
      end
      beats_due.push_back(e);
    endfunction

    function string show(parse_beat_t x);
      return $sformatf({"strobe=%0d byte=%02h idx=%0d done=%0d ok=%0d status=%0d len=%0d ",
                        "seq=%0d sys=%0d comp=%0d msg=%0d fill=%02h"},
                       x.strobe, x.pbyte, x.pindex, x.done, x.ok, x.status, x.length,
                       x.seq, x.sysid, x.compid, x.msgid, x.fill);
    endfunction

    function void check_beat(logic [63:0] tdata, logic tuser, logic tlast);
      parse_beat_t got, want;
      got = {tuser, tlast, tdata};
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %s", show(got));
        return;
      end
      want = beats_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("beat mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start_byte_we = 1'b0;
  logic [7:0]  start_byte_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // payload_byte, payload_index, frame_ok, frame_status,
                                  // frame_length, frame_seq, frame_sysid, frame_compid,
                                  // frame_msgid, zero fill
  logic        m_tuser;           // payload_strobe
  logic        m_tlast;           // frame_done

  parser_scoreboard sb;
  logic [7:0] frame_q[$];
  logic [7:0] cur_start = START_INIT;
  int         rx_sent = 0;
  int         stall_left = 0;
  bit         idle_on = 1'b1;

  mavlink_v1_frame_parser dut (
    .clk              (clk),
    .rst              (rst),
    .start_byte_we    (start_byte_we),
    .start_byte_wdata (start_byte_wdata),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .m_tlast          (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_rx_byte(b);
    rx_sent++;
  endtask

  task automatic send_span(input int from, input int to);
    int i;
    for (i = from; i < to; i++) send_byte(frame_q[i]);
  endtask

  task automatic build_frame(input int len, input logic [7:0] msgid, input bit corrupt,
                             input bit start_first);
    logic [15:0] crc;
    logic [7:0]  b;
    int          i;
    frame_q.delete();
    frame_q.push_back(cur_start);
    frame_q.push_back(8'(len));
    repeat (3) frame_q.push_back(8'($urandom));
    frame_q.push_back(msgid);
    for (i = 0; i < len; i++) begin
      // start byte inside the payload is plain data
      if ((i == 0 && start_first) || $urandom_range(0, 15) == 0) b = cur_start;
      else b = 8'($urandom);
      frame_q.push_back(b);
    end
    crc = CRC_INIT;
    for (i = 1; i < frame_q.size(); i++) crc = sb.crc_next(crc, frame_q[i]);
    crc = sb.crc_next(crc, sb.extra_for(msgid));
    if (corrupt) crc ^= 16'(1) << $urandom_range(0, 15);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.beats_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    @(negedge clk);
    start_byte_we <= 1'b1;
    start_byte_wdata <= v;
    @(posedge clk);
    sb.set_start(v);
    cur_start = v;
    @(negedge clk);
    start_byte_we <= 1'b0;
  endtask

  task automatic run_phase(input int budget, input bit hold_once);
    int         stop, len, r, r2, n;
    bit         held;
    logic [7:0] id;
    held = 1'b0;
    stop = rx_sent + budget;
    while (rx_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        r2 = $urandom_range(0, 99);
        if (r2 < 3) len = $urandom_range(17, 255);
        else if (r2 < 10) len = 0;
        else len = $urandom_range(1, 16);
        if ($urandom_range(0, 99) < 85) id = 8'($urandom_range(0, 99));
        else id = 8'($urandom_range(100, 255));
        build_frame(len, id, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
        // broken frame: cut short somewhere
        if (r < 16) n = $urandom_range(1, frame_q.size() - 1);
        else n = frame_q.size();
        if (hold_once && !held && n > 6) begin
          send_span(0, 4);
          wait_drained();
          send_span(4, n);
          held = 1'b1;
        end else begin
          send_span(0, n);
        end
      end
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && !rst && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hunt noise, shortest good frame, unknown id over bad crc, last known id with bad crc
    send_byte(8'h00);
    send_byte(8'hFF);
    build_frame(0, 8'd0, 1'b0, 1'b0);
    send_span(0, frame_q.size());
    build_frame(1, 8'd255, 1'b1, 1'b1);
    send_span(0, frame_q.size());
    build_frame(0, 8'd99, 1'b1, 1'b0);
    send_span(0, frame_q.size());

    wait_drained();
    write_start(8'h00);
    build_frame(255, 8'd0, 1'b0, 1'b1);
    send_span(0, frame_q.size());
    run_phase(380, 1'b0);
    // leave a frame open across the register write
    build_frame(4, 8'd1, 1'b0, 1'b0);
    send_span(0, 3);

    wait_drained();
    write_start(8'hFF);
    run_phase(380, 1'b1);

    wait_drained();
    write_start(8'($urandom));
    run_phase(380, 1'b0);

    wait_drained();
    idle_on = 1'b0;
    write_start(START_INIT);
    run_phase(380, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.beats_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
